/* sv/call_stack_profiler_macros.svh */
// Assertion macros shared by the call stack profiler RTL.
`ifndef CALL_STACK_PROFILER_MACROS_SVH
`define CALL_STACK_PROFILER_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, checked on every clock edge outside reset.
`define CSP_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication, checked on every clock edge outside reset.
`define CSP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define CSP_ASSERT_NOW(lbl, ante, cons, msg)
`define CSP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* sv/csp_pkg.sv */
// Types, constants and codes shared by the call stack profiler modules.
`default_nettype none
package csp_pkg;

   localparam int NUM_FUNCS    = 256;
   localparam int STACK_DEPTH  = 64;
   localparam int FUNC_AW      = $clog2(NUM_FUNCS);
   localparam int STACK_AW     = $clog2(STACK_DEPTH);
   localparam int LEVEL_W      = $clog2(STACK_DEPTH + 1);
   localparam int ID_W         = 8;
   localparam int TIME_W       = 64;
   localparam int LEVEL_OUT_W  = 7;
   localparam int ROW_W        = 3 * TIME_W;
   localparam int FRAME_W      = ID_W + TIME_W;

   typedef enum logic [1:0] {
      KIND_ENTER = 2'd0,
      KIND_EXIT  = 2'd1,
      KIND_READ  = 2'd2,
      KIND_CLEAR = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_ENTERED  = 3'd0,
      ST_EXITED   = 3'd1,
      ST_EMPTY    = 3'd2,
      ST_OVERFLOW = 3'd3,
      ST_IGNORED  = 3'd4,
      ST_DONE     = 3'd5
   } status_type;

   typedef struct packed {
      kind_type              kind;
      logic [ID_W-1:0]       func_id;
      logic [TIME_W-1:0]     now_us;
   } req_type;

   typedef struct packed {
      status_type            status;
      logic [ID_W-1:0]       entry_id;
      logic [TIME_W-1:0]     call_total;
      logic [TIME_W-1:0]     incl_total;
      logic [TIME_W-1:0]     excl_total;
      logic [LEVEL_OUT_W-1:0] stack_level;
   } rsp_type;

   // One row of the counter table.
   typedef struct packed {
      logic [TIME_W-1:0] calls;
      logic [TIME_W-1:0] incl;
      logic [TIME_W-1:0] excl;
   } row_type;

   // One stack frame apart from its child time, which has its own memory.
   typedef struct packed {
      logic [ID_W-1:0]   func;
      logic [TIME_W-1:0] start;
   } frame_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_READ,
      S_ENTER,
      S_EX_FETCH,
      S_EX_EXCL,
      S_EX_ISUM,
      S_EX_ESUM,
      S_EX_PARENT
   } state_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_INC,
      OP_INCL,
      OP_EXCL,
      OP_ISUM,
      OP_ESUM,
      OP_PCHILD
   } alu_op_type;

   typedef enum logic [2:0] {
      SRC_NONE,
      SRC_ID,
      SRC_RDROW,
      SRC_NEWROW,
      SRC_FRAME
   } rsp_src_type;

   typedef struct packed {
      kind_type kind;
      logic     failed;
      logic     can_push;
      logic     empty;
      logic     has_parent;
   } seq_stat_type;

   typedef struct packed {
      logic        busy;
      logic        capture;
      logic        rd_cnt;
      logic        cnt_addr_frame;
      logic        rd_stack;
      logic        rd_parent;
      alu_op_type  alu_op;
      logic        push;
      logic        pop;
      logic        wr_parent;
      logic        clear;
      logic        set_failed;
      logic        respond;
      status_type  status;
      rsp_src_type src;
   } seq_ctrl_type;

endpackage
`default_nettype wire

/* sv/call_stack_profiler.sv */
// Top level of the call stack profiler: datapath, counter table and frame stack.
//
// Usage: the trace source drives a word on req_data (kind, func_id, now_us)
// and raises start. The word is taken at the clock edge where start is high
// and busy is low; busy then stays high while the word is worked on.
// Every word gives exactly one result word on rsp_data, shown for a single
// cycle with rsp_strobe high. The receiver must take it in that cycle; it
// has no way to stall the block.
// Clear, ignored, empty-stack and overflow words are handled in the decode
// state alone; enter and read words (a read also while failed) pass through
// decode and an enter or read state, and an exit through decode, fetch,
// exclusive, inclusive-sum, exclusive-sum and parent states. The result
// strobe is high in the first cycle with busy low, and a new word may be
// offered in that same cycle. Busy time is set by the single 64-bit adder,
// which an exit uses five times in a row (inclusive time, exclusive time, two
// sums, parent child time), and by the registered read ports of the counter
// and stack memories. Reset (synchronous, active high) empties the stack,
// clears the failed flag and marks every counter row as zero through per-row
// valid bits, so no clearing pass is needed; a clear word does the same.
`default_nettype none
`include "call_stack_profiler_macros.svh"
module call_stack_profiler (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  csp_pkg::req_type req_data,
   output logic             rsp_strobe,
   output csp_pkg::rsp_type rsp_data
);
   import csp_pkg::*;

   // Sequencer interface.
   seq_stat_type stat;
   seq_ctrl_type ctrl;

   // The accepted word is held here until its result goes out.
   req_type req_ff;

   // Stack depth and sticky failure flag.
   logic [LEVEL_W-1:0] count_ff;
   logic [LEVEL_W-1:0] count_in;
   logic               failed_ff;
   logic               failed_in;

   // One valid bit per counter row; a row without it reads as zero.
   logic [NUM_FUNCS-1:0] cnt_vld_ff;
   logic                 rd_vld_ff;

   // Exit working registers.
   logic [TIME_W-1:0] incl_ff;
   logic [TIME_W-1:0] excl_ff;
   logic [TIME_W-1:0] child_ff;
   logic [ID_W-1:0]   func_ff;
   row_type           row_ff;

   // Result register.
   logic    rsp_strobe_ff;
   rsp_type rsp_data_ff;
   rsp_type rsp_in;

   // Memory ports.
   logic [FUNC_AW-1:0]  cnt_wr_addr;
   logic [FUNC_AW-1:0]  cnt_rd_addr;
   row_type             cnt_wr_data;
   logic [ROW_W-1:0]    cnt_rd_data;
   logic [FRAME_W-1:0]  frame_rd_data;
   frame_type           frame_rd;
   frame_type           frame_wr;
   logic                child_wr_en;
   logic [STACK_AW-1:0] child_wr_addr;
   logic [TIME_W-1:0]   child_wr_data;
   logic                child_rd_en;
   logic [STACK_AW-1:0] child_rd_addr;
   logic [TIME_W-1:0]   child_rd;

   // Derived values.
   logic                fid_in_range;
   logic [FUNC_AW-1:0]  fid_idx;
   logic [STACK_AW-1:0] push_idx;
   logic [STACK_AW-1:0] top_idx;
   logic [STACK_AW-1:0] parent_idx;
   logic                rd_in_range;
   row_type             row_rd;
   row_type             row_new;

   // Shared adder.
   logic [TIME_W-1:0] alu_a;
   logic [TIME_W-1:0] alu_b;
   logic              alu_sub;
   logic [TIME_W-1:0] alu_res;
   logic              alu_borrow;

   assign fid_in_range = (32'(req_ff.func_id) < 32'(NUM_FUNCS));
   assign fid_idx      = FUNC_AW'(req_ff.func_id);
   assign push_idx     = STACK_AW'(count_ff);
   assign top_idx      = STACK_AW'(count_ff - LEVEL_W'(1));
   assign parent_idx   = STACK_AW'(count_ff - LEVEL_W'(2));

   assign stat.kind       = req_ff.kind;
   assign stat.failed     = failed_ff;
   assign stat.can_push   = fid_in_range && (count_ff < LEVEL_W'(STACK_DEPTH));
   assign stat.empty      = (count_ff == '0);
   assign stat.has_parent = (count_ff > LEVEL_W'(1));

   csp_seq u_seq (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .ctrl  (ctrl)
   );

   assign busy = ctrl.busy;

   always_ff @(posedge clock) begin
      if (ctrl.capture) begin
         req_ff <= req_data;
      end
   end

   // Counter table. A row read for a function outside the table, or one
   // not written since the last clear, is seen as all zero.
   assign cnt_rd_addr = ctrl.cnt_addr_frame ? FUNC_AW'(frame_rd.func) : fid_idx;
   assign rd_in_range = ctrl.cnt_addr_frame | fid_in_range;
   assign cnt_wr_addr = ctrl.pop ? FUNC_AW'(func_ff) : fid_idx;
   assign cnt_wr_data = ctrl.pop ? row_ff : row_new;

   csp_ram #(
      .WIDTH (ROW_W),
      .DEPTH (NUM_FUNCS)
   ) u_cnt_ram (
      .clock   (clock),
      .wr_en   (ctrl.push | ctrl.pop),
      .wr_addr (cnt_wr_addr),
      .wr_data (cnt_wr_data),
      .rd_en   (ctrl.rd_cnt),
      .rd_addr (cnt_rd_addr),
      .rd_data (cnt_rd_data)
   );

   assign row_rd = rd_vld_ff ? row_type'(cnt_rd_data) : '0;

   always_comb begin
      row_new       = row_rd;
      row_new.calls = alu_res;
   end

   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         cnt_vld_ff <= '0;
         rd_vld_ff  <= 1'b0;
      end else begin
         if (ctrl.push || ctrl.pop) begin
            cnt_vld_ff[cnt_wr_addr] <= 1'b1;
         end
         if (ctrl.rd_cnt) begin
            rd_vld_ff <= rd_in_range && cnt_vld_ff[cnt_rd_addr];
         end
      end
   end

   // Frame stack: function id and start time in one memory, child time in
   // another so that the parent's child time can be updated on an exit.
   assign frame_wr.func  = req_ff.func_id;
   assign frame_wr.start = req_ff.now_us;

   csp_ram #(
      .WIDTH (FRAME_W),
      .DEPTH (STACK_DEPTH)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (ctrl.push),
      .wr_addr (push_idx),
      .wr_data (frame_wr),
      .rd_en   (ctrl.rd_stack),
      .rd_addr (top_idx),
      .rd_data (frame_rd_data)
   );

   assign frame_rd = frame_type'(frame_rd_data);

   assign child_wr_en   = ctrl.push | ctrl.wr_parent;
   assign child_wr_addr = ctrl.push ? push_idx : parent_idx;
   assign child_wr_data = ctrl.push ? '0 : alu_res;
   assign child_rd_en   = ctrl.rd_stack | ctrl.rd_parent;
   assign child_rd_addr = ctrl.rd_parent ? parent_idx : top_idx;

   csp_ram #(
      .WIDTH (TIME_W),
      .DEPTH (STACK_DEPTH)
   ) u_child_ram (
      .clock   (clock),
      .wr_en   (child_wr_en),
      .wr_addr (child_wr_addr),
      .wr_data (child_wr_data),
      .rd_en   (child_rd_en),
      .rd_addr (child_rd_addr),
      .rd_data (child_rd)
   );

   // Operand selection for the shared adder, one operation per sequencer step.
   always_comb begin
      alu_a   = '0;
      alu_b   = '0;
      alu_sub = 1'b0;
      unique case (ctrl.alu_op)
         OP_INC: begin
            alu_a = row_rd.calls;
            alu_b = TIME_W'(1);
         end
         OP_INCL: begin
            alu_a   = req_ff.now_us;
            alu_b   = frame_rd.start;
            alu_sub = 1'b1;
         end
         OP_EXCL: begin
            alu_a   = incl_ff;
            alu_b   = child_ff;
            alu_sub = 1'b1;
         end
         OP_ISUM: begin
            alu_a = row_ff.incl;
            alu_b = incl_ff;
         end
         OP_ESUM: begin
            alu_a = row_ff.excl;
            alu_b = excl_ff;
         end
         OP_PCHILD: begin
            alu_a = child_rd;
            alu_b = incl_ff;
         end
         default: ;
      endcase
   end

   csp_alu u_alu (
      .op_a   (alu_a),
      .op_b   (alu_b),
      .sub    (alu_sub),
      .result (alu_res),
      .borrow (alu_borrow)
   );

   // Exit working registers. Exclusive time is floored at zero when the
   // children took longer than the frame itself.
   always_ff @(posedge clock) begin
      unique case (ctrl.alu_op)
         OP_INCL: begin
            incl_ff  <= alu_res;
            func_ff  <= frame_rd.func;
            child_ff <= child_rd;
         end
         OP_EXCL: begin
            excl_ff <= alu_borrow ? '0 : alu_res;
            row_ff  <= row_rd;
         end
         OP_ISUM: row_ff.incl <= alu_res;
         OP_ESUM: row_ff.excl <= alu_res;
         default: ;
      endcase
   end

   // Stack depth and failure flag.
   always_comb begin
      count_in  = count_ff;
      failed_in = failed_ff;
      if (ctrl.clear) begin
         count_in  = '0;
         failed_in = 1'b0;
      end else begin
         if (ctrl.push) begin
            count_in = count_ff + LEVEL_W'(1);
         end else if (ctrl.pop) begin
            count_in = count_ff - LEVEL_W'(1);
         end
         if (ctrl.set_failed) begin
            failed_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         failed_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         failed_ff <= failed_in;
      end
   end

   // Result word. The stack level reported is the one after this word.
   always_comb begin
      rsp_in             = '0;
      rsp_in.status      = ctrl.status;
      rsp_in.stack_level = LEVEL_OUT_W'(count_in);
      unique case (ctrl.src)
         SRC_NONE: ;
         SRC_ID: begin
            rsp_in.entry_id = req_ff.func_id;
         end
         SRC_RDROW: begin
            rsp_in.entry_id   = req_ff.func_id;
            rsp_in.call_total = row_rd.calls;
            rsp_in.incl_total = row_rd.incl;
            rsp_in.excl_total = row_rd.excl;
         end
         SRC_NEWROW: begin
            rsp_in.entry_id   = req_ff.func_id;
            rsp_in.call_total = row_new.calls;
            rsp_in.incl_total = row_new.incl;
            rsp_in.excl_total = row_new.excl;
         end
         SRC_FRAME: begin
            rsp_in.entry_id   = func_ff;
            rsp_in.call_total = row_ff.calls;
            rsp_in.incl_total = row_ff.incl;
            rsp_in.excl_total = row_ff.excl;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= ctrl.respond;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.respond) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   `CSP_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
   `CSP_ASSERT_NEXT(a_strobe_single, rsp_strobe, !rsp_strobe, "result strobe held two cycles")
   `CSP_ASSERT_NOW(a_level_bound, 1'b1, count_ff <= LEVEL_W'(STACK_DEPTH), "stack level too high")
   `CSP_ASSERT_NOW(a_push_legal, ctrl.push, !failed_ff && count_ff < LEVEL_W'(STACK_DEPTH), "bad push")
   `CSP_ASSERT_NOW(a_pop_legal, ctrl.pop, count_ff != '0 && !failed_ff, "pop from empty stack")

endmodule
`default_nettype wire

/* sv/csp_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module csp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AddrW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AddrW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* sv/csp_alu.sv */
// Shared 64-bit adder and subtractor with a borrow flag.
`default_nettype none
module csp_alu (
   input  logic [csp_pkg::TIME_W-1:0] op_a,
   input  logic [csp_pkg::TIME_W-1:0] op_b,
   input  logic                       sub,
   output logic [csp_pkg::TIME_W-1:0] result,
   output logic                       borrow
);
   import csp_pkg::*;

   logic [TIME_W:0] wide;

   always_comb begin
      if (sub) begin
         wide = {1'b0, op_a} - {1'b0, op_b};
      end else begin
         wide = {1'b0, op_a} + {1'b0, op_b};
      end
   end

   assign result = wide[TIME_W-1:0];
   // The top bit of a subtraction is set exactly when op_b exceeds op_a.
   assign borrow = sub & wide[TIME_W];

endmodule
`default_nettype wire

/* sv/csp_seq.sv */
// Sequencer that steps one profiler word through the shared datapath.
`default_nettype none
module csp_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  csp_pkg::seq_stat_type stat,
   output csp_pkg::seq_ctrl_type ctrl
);
   import csp_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (stat.kind)
               KIND_CLEAR: state_in = S_IDLE;
               KIND_READ:  state_in = S_READ;
               KIND_ENTER: begin
                  if (stat.failed || !stat.can_push) begin
                     state_in = S_IDLE;
                  end else begin
                     state_in = S_ENTER;
                  end
               end
               KIND_EXIT: begin
                  if (stat.failed || stat.empty) begin
                     state_in = S_IDLE;
                  end else begin
                     state_in = S_EX_FETCH;
                  end
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_READ:      state_in = S_IDLE;
         S_ENTER:     state_in = S_IDLE;
         S_EX_FETCH:  state_in = S_EX_EXCL;
         S_EX_EXCL:   state_in = S_EX_ISUM;
         S_EX_ISUM:   state_in = S_EX_ESUM;
         S_EX_ESUM:   state_in = S_EX_PARENT;
         S_EX_PARENT: state_in = S_IDLE;
         default:     state_in = S_IDLE;
      endcase
   end

   always_comb begin
      ctrl      = '0;
      ctrl.busy = (state_ff != S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            ctrl.capture = start;
         end
         S_DECODE: begin
            unique case (stat.kind)
               KIND_CLEAR: begin
                  ctrl.clear   = 1'b1;
                  ctrl.respond = 1'b1;
                  ctrl.status  = ST_DONE;
                  ctrl.src     = SRC_NONE;
               end
               KIND_READ: begin
                  ctrl.rd_cnt = 1'b1;
               end
               KIND_ENTER: begin
                  if (stat.failed) begin
                     ctrl.respond = 1'b1;
                     ctrl.status  = ST_IGNORED;
                     ctrl.src     = SRC_NONE;
                  end else if (!stat.can_push) begin
                     ctrl.set_failed = 1'b1;
                     ctrl.respond    = 1'b1;
                     ctrl.status     = ST_OVERFLOW;
                     ctrl.src        = SRC_ID;
                  end else begin
                     ctrl.rd_cnt = 1'b1;
                  end
               end
               KIND_EXIT: begin
                  if (stat.failed) begin
                     ctrl.respond = 1'b1;
                     ctrl.status  = ST_IGNORED;
                     ctrl.src     = SRC_NONE;
                  end else if (stat.empty) begin
                     ctrl.respond = 1'b1;
                     ctrl.status  = ST_EMPTY;
                     ctrl.src     = SRC_NONE;
                  end else begin
                     ctrl.rd_stack = 1'b1;
                  end
               end
               default: ;
            endcase
         end
         S_READ: begin
            ctrl.respond = 1'b1;
            ctrl.status  = ST_DONE;
            ctrl.src     = SRC_RDROW;
         end
         S_ENTER: begin
            ctrl.alu_op  = OP_INC;
            ctrl.push    = 1'b1;
            ctrl.respond = 1'b1;
            ctrl.status  = ST_ENTERED;
            ctrl.src     = SRC_NEWROW;
         end
         S_EX_FETCH: begin
            ctrl.alu_op         = OP_INCL;
            ctrl.rd_cnt         = 1'b1;
            ctrl.cnt_addr_frame = 1'b1;
            ctrl.rd_parent      = 1'b1;
         end
         S_EX_EXCL: begin
            ctrl.alu_op = OP_EXCL;
         end
         S_EX_ISUM: begin
            ctrl.alu_op = OP_ISUM;
         end
         S_EX_ESUM: begin
            ctrl.alu_op = OP_ESUM;
         end
         S_EX_PARENT: begin
            ctrl.alu_op    = OP_PCHILD;
            ctrl.pop       = 1'b1;
            ctrl.wr_parent = stat.has_parent;
            ctrl.respond   = 1'b1;
            ctrl.status    = ST_EXITED;
            ctrl.src       = SRC_FRAME;
         end
         default: ;
      endcase
   end

endmodule
`default_nettype wire
